>>> src/planar_dpcm_residual_defines.svh
// Assertion macros for the planar DPCM residual block.
// Used by planar_dpcm_residual.sv; expects clk and arst_n in scope.
`ifndef PLANAR_DPCM_RESIDUAL_DEFINES_SVH
`define PLANAR_DPCM_RESIDUAL_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PDR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define PDR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/pdr_pkg.sv
// Shared constants and types of the planar DPCM residual block.
// No dependencies; used by the interfaces and the top level.
package pdr_pkg;

	// Image geometry limits.
	localparam int MAX_WIDTH   = 4096;
	localparam int COL_BITS    = $clog2(MAX_WIDTH);
	localparam int PIXEL_BITS  = 8;
	localparam int RESID_BITS  = PIXEL_BITS + 2;
	localparam int WIDTH_BITS  = 13;
	localparam int HEIGHT_BITS = 16;
	localparam int CFG_BITS    = 16;
	localparam int IDX_BITS    = 1;

	typedef logic [PIXEL_BITS-1:0]        pixel_t;
	typedef logic signed [RESID_BITS-1:0] resid_t;
	typedef logic [COL_BITS-1:0]          col_t;
	typedef logic [HEIGHT_BITS-1:0]       row_t;

	// Configuration register indexes.
	typedef enum logic [IDX_BITS-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(MAX_WIDTH);
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(1);

endpackage

>>> src/pdr_pixel_if.sv
// Valid/ready channel that carries one pixel word.
// Depends on pdr_pkg.
interface pdr_pixel_if;
	logic            valid;
	logic            ready;
	pdr_pkg::pixel_t pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

>>> src/pdr_resid_if.sv
// Valid/ready channel that carries one residual word and its frame-end flag.
// Depends on pdr_pkg.
interface pdr_resid_if;
	logic            valid;
	logic            ready;
	pdr_pkg::resid_t residual;
	logic            frame_end;

	modport source (output valid, output residual, output frame_end, input ready);
	modport sink (input valid, input residual, input frame_end, output ready);
endinterface

>>> src/planar_dpcm_residual.sv
// Planar DPCM residual generator: top level with line buffer and counters.
// Depends on pdr_pkg, pdr_pixel_if, pdr_resid_if and the defines header.
//
// Usage:
//   Pixels enter in raster order on the pixels channel; one residual word
//   per pixel leaves on the residuals channel, with frame_end high on the
//   last pixel of the frame. The first pixel of a frame passes unchanged,
//   the first row subtracts the left pixel, the first column the pixel
//   above, and all others compute pixel - left - above + upper-left.
//   frame_width and frame_height are set through the write port, by the
//   user only while idle; the block itself does not enforce this.
//   A residual word passes the pixel stage and then the output register.
//   Throughput is one pixel per clock unless the receiver stalls: the line
//   buffer memory is read once when a pixel is accepted and written once
//   when its residual is formed, bypassed when both hit the same column.
//   Reset clears counters, neighbor registers and both pipeline stages and
//   loads width 4096, height 1; the line buffer itself is not cleared.
//   When the receiver stalls, the output register and the pixel stage hold,
//   and input ready drops only once both are full.
`include "planar_dpcm_residual_defines.svh"

module planar_dpcm_residual (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pdr_pkg::IDX_BITS-1:0]   cfg_index,
	input  logic [pdr_pkg::CFG_BITS-1:0]   cfg_data,
	pdr_pixel_if.sink                      pixels,
	pdr_resid_if.source                    residuals
);

	// Configuration registers.
	logic [pdr_pkg::WIDTH_BITS-1:0]  frame_width_q;
	logic [pdr_pkg::HEIGHT_BITS-1:0] frame_height_q;

	// Scan counters and neighbor state.
	pdr_pkg::col_t   column_count_q;
	pdr_pkg::row_t   row_count_q;
	pdr_pkg::pixel_t left_q;
	pdr_pkg::pixel_t upper_left_q;

	// Line buffer.
	pdr_pkg::pixel_t row_store [pdr_pkg::MAX_WIDTH];

	// Pixel stage.
	logic            valid_s1;
	pdr_pkg::pixel_t pixel_s1;
	pdr_pkg::col_t   col_s1;
	logic            first_row_s1;
	logic            first_col_s1;
	logic            frame_end_s1;
	pdr_pkg::pixel_t above_rd_s1;
	logic            fwd_s1;
	pdr_pkg::pixel_t fwd_pixel_s1;

	// Output register.
	logic            out_valid_q;
	pdr_pkg::resid_t residual_q;
	logic            frame_end_q;

	logic                             accept;
	logic                             s1_adv;
	logic [pdr_pkg::WIDTH_BITS-1:0]   eff_width;
	logic [pdr_pkg::HEIGHT_BITS-1:0]  eff_height;
	logic                             last_col;
	logic                             last_row;
	logic [pdr_pkg::COL_BITS:0]       col_next;
	logic [pdr_pkg::HEIGHT_BITS:0]    row_next;
	logic                             fwd_hit;
	pdr_pkg::pixel_t                  above;
	pdr_pkg::resid_t                  px_x;
	pdr_pkg::resid_t                  left_x;
	pdr_pkg::resid_t                  above_x;
	pdr_pkg::resid_t                  ul_x;
	pdr_pkg::resid_t                  resid_d;

	// Handshake: the pixel stage moves on when the output register is free.
	assign s1_adv          = valid_s1 && (!out_valid_q || residuals.ready);
	assign pixels.ready    = !valid_s1 || s1_adv;
	assign accept          = pixels.valid && pixels.ready;
	assign residuals.valid     = out_valid_q;
	assign residuals.residual  = residual_q;
	assign residuals.frame_end = frame_end_q;

	// Effective frame size: zero acts as one, width saturates at the buffer size.
	always_comb begin
		if (frame_width_q == '0) begin
			eff_width = pdr_pkg::WIDTH_BITS'(1);
		end else if (frame_width_q > pdr_pkg::WIDTH_BITS'(pdr_pkg::MAX_WIDTH)) begin
			eff_width = pdr_pkg::WIDTH_BITS'(pdr_pkg::MAX_WIDTH);
		end else begin
			eff_width = frame_width_q;
		end
		eff_height = (frame_height_q == '0) ? pdr_pkg::HEIGHT_BITS'(1) : frame_height_q;
	end

	// End-of-row and end-of-frame decisions for the pixel being accepted.
	assign col_next = {1'b0, column_count_q} + 1'b1;
	assign row_next = {1'b0, row_count_q} + 1'b1;
	assign last_col = pdr_pkg::WIDTH_BITS'(col_next) >= eff_width;
	assign last_row = row_next >= {1'b0, eff_height};

	// A write by the leaving pixel to the column being read must be bypassed.
	assign fwd_hit = accept && s1_adv && (col_s1 == column_count_q);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= pdr_pkg::WIDTH_RESET;
			frame_height_q <= pdr_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdr_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[pdr_pkg::WIDTH_BITS-1:0];
				pdr_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[pdr_pkg::HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Scan counters advance on every accepted pixel word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (accept) begin
			if (last_col) begin
				column_count_q <= '0;
				row_count_q    <= last_row ? '0 : row_next[pdr_pkg::HEIGHT_BITS-1:0];
			end else begin
				column_count_q <= col_next[pdr_pkg::COL_BITS-1:0];
			end
		end
	end

	// Line buffer: read on accept, write when the stored pixel leaves.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			row_store[col_s1] <= pixel_s1;
		end
		if (accept) begin
			above_rd_s1 <= row_store[column_count_q];
		end
	end

	// Pixel stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1     <= pixels.pixel;
			col_s1       <= column_count_q;
			first_row_s1 <= (row_count_q == '0);
			first_col_s1 <= (column_count_q == '0);
			frame_end_s1 <= last_col && last_row;
			fwd_s1       <= fwd_hit;
			fwd_pixel_s1 <= pixel_s1;
		end
	end

	// Pixel stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	// Predictor arithmetic, wrapped to the residual width.
	assign above   = fwd_s1 ? fwd_pixel_s1 : above_rd_s1;
	assign px_x    = pdr_pkg::resid_t'({{(pdr_pkg::RESID_BITS-pdr_pkg::PIXEL_BITS){1'b0}},
		pixel_s1});
	assign left_x  = pdr_pkg::resid_t'({{(pdr_pkg::RESID_BITS-pdr_pkg::PIXEL_BITS){1'b0}},
		left_q});
	assign above_x = pdr_pkg::resid_t'({{(pdr_pkg::RESID_BITS-pdr_pkg::PIXEL_BITS){1'b0}},
		above});
	assign ul_x    = pdr_pkg::resid_t'({{(pdr_pkg::RESID_BITS-pdr_pkg::PIXEL_BITS){1'b0}},
		upper_left_q});

	always_comb begin
		if (first_row_s1 && first_col_s1) begin
			resid_d = px_x;
		end else if (first_row_s1) begin
			resid_d = px_x - left_x;
		end else if (first_col_s1) begin
			resid_d = px_x - above_x;
		end else begin
			resid_d = px_x - left_x - above_x + ul_x;
		end
	end

	// Neighbor registers follow the pixel that leaves the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
		end else if (s1_adv) begin
			left_q       <= pixel_s1;
			upper_left_q <= above;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			residual_q  <= resid_d;
			frame_end_q <= frame_end_s1;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (residuals.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Checks on counter and pipeline behavior.
	`PDR_ASSERT_NEXT(a_col_wrap, accept && last_col, column_count_q == '0, "column did not wrap")
	`PDR_ASSERT_NEXT(a_col_step, accept && !last_col, column_count_q == $past(column_count_q) + 1'b1, "column did not step")
	`PDR_ASSERT_NEXT(a_frame_wrap, accept && last_col && last_row, row_count_q == '0, "row did not wrap at frame end")
	`PDR_ASSERT_NOW(a_fwd_only_s1, fwd_hit, valid_s1 && accept, "bypass without a leaving and an entering pixel")

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for planar_dpcm_residual: drives pixel words, predicts residuals.
// Depends on pdr_pkg, pdr_pixel_if, pdr_resid_if and the planar_dpcm_residual RTL.
// Runs directed corner frames, then random frame sizes and pixels with random idle gaps.
module tb_top;
	import pdr_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int PIXEL_TARGET = 1120;
	localparam pixel_t CORNER_FRAME [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
		8'd0, 8'd255, 8'd0};

	typedef struct packed {
		resid_t residual;
		logic   frame_end;
	} resid_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic cfg_we;
	logic [IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	pdr_pixel_if pixel_ch ();
	pdr_resid_if resid_ch ();

	planar_dpcm_residual u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pixel_ch),
		.residuals (resid_ch)
	);

	// Pixel words waiting to be sent and residual words still owed by the block.
	pixel_t      pixel_backlog [$];
	resid_word_t pending_residuals [$];
	int pixels_queued = 0;
	int pixels_taken = 0;
	int frames_seen = 0;
	int register_writes = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	int sender_gap_max = 0;
	int receiver_stall_max = 0;
	int send_gap;
	int stall_left;

	// Mirror of the block's registers and image state.
	logic [WIDTH_BITS-1:0]  frame_width_reg = WIDTH_RESET;
	logic [HEIGHT_BITS-1:0] frame_height_reg = HEIGHT_RESET;
	bit [PIXEL_BITS-1:0] line_store [MAX_WIDTH];
	bit line_written [MAX_WIDTH];
	int left_pixel = 0;
	int upper_left = 0;
	int column_count = 0;
	int row_count = 0;

	always #10 clk = ~clk;

	// A zero width acts as one column, anything above the line buffer as its full size.
	function automatic int active_width(input logic [WIDTH_BITS-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_WIDTH)
			return MAX_WIDTH;
		return int'(raw);
	endfunction

	// Computes the residual word of one pixel and advances the image position.
	function automatic resid_word_t dpcm_predict(input pixel_t px);
		int w, h, slot, above, p, r;
		bit last_col, last_row;
		resid_word_t word;
		p = int'(px);
		w = active_width(frame_width_reg);
		h = (frame_height_reg == 0) ? 1 : int'(frame_height_reg);
		slot = (column_count < MAX_WIDTH) ? column_count : MAX_WIDTH - 1;
		above = int'(line_store[slot]);
		last_col = (column_count + 1) >= w;
		last_row = (row_count + 1) >= h;
		if (row_count == 0 && column_count == 0)
			r = p;
		else if (row_count == 0)
			r = p - left_pixel;
		else if (column_count == 0)
			r = p - above;
		else
			r = p - left_pixel - above + upper_left;
		word.residual = r[RESID_BITS-1:0];
		word.frame_end = last_col && last_row;
		upper_left = above;
		line_store[slot] = px;
		line_written[slot] = 1'b1;
		left_pixel = p;
		if (last_col) begin
			column_count = 0;
			row_count = last_row ? 0 : row_count + 1;
		end else begin
			column_count = column_count + 1;
		end
		return word;
	endfunction

	// A width change mid-frame must not make the current row read a line buffer
	// entry that was never written since reset.
	function automatic bit width_change_safe(input logic [WIDTH_BITS-1:0] raw);
		int last;
		if (row_count == 0)
			return 1'b1;
		last = active_width(raw) - 1;
		if (last < column_count)
			last = column_count;
		for (int s = column_count; s <= last; s++) begin
			if (!line_written[s])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic write_register(input reg_idx_t index, input logic [CFG_BITS-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_FRAME_WIDTH)
			frame_width_reg = value[WIDTH_BITS-1:0];
		else
			frame_height_reg = value[HEIGHT_BITS-1:0];
		register_writes++;
	endtask

	task automatic queue_pixel(input pixel_t value);
		pixel_backlog.push_back(value);
		pixels_queued++;
	endtask

	// Waits until every queued pixel word is taken and every residual word is back.
	task automatic wait_idle();
		while (pixels_taken != pixels_queued || pending_residuals.size() != 0)
			@(posedge clk);
	endtask

	// Pixel driver: holds a word until it is taken, then waits a random gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_ch.valid <= 1'b0;
			pixel_ch.pixel <= '0;
			send_gap <= 0;
		end else if (!pixel_ch.valid || pixel_ch.ready) begin
			if (send_gap != 0) begin
				pixel_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pixel_backlog.size() != 0) begin
				pixel_ch.valid <= 1'b1;
				pixel_ch.pixel <= pixel_backlog.pop_front();
				send_gap <= $urandom_range(0, sender_gap_max);
			end else begin
				pixel_ch.valid <= 1'b0;
			end
		end
	end

	// Residual receiver: after each word it may drop ready for a random stall.
	always @(posedge clk or negedge arst_n) begin : receiver_ready
		int stall_draw;
		if (!arst_n) begin
			resid_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (resid_ch.valid && resid_ch.ready) begin
			stall_draw = $urandom_range(0, receiver_stall_max);
			resid_ch.ready <= (stall_draw == 0);
			stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
		end else if (stall_left != 0) begin
			resid_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			resid_ch.ready <= 1'b1;
		end
	end

	// Every pixel word taken by the block adds one predicted residual word.
	always @(posedge clk) begin
		if (arst_n && pixel_ch.valid && pixel_ch.ready) begin
			pending_residuals.push_back(dpcm_predict(pixel_ch.pixel));
			pixels_taken++;
		end
	end

	// Compares each residual word with the oldest prediction.
	always @(posedge clk) begin : residual_check
		resid_word_t want;
		if (arst_n && resid_ch.valid && resid_ch.ready) begin
			if (pending_residuals.size() == 0) begin
				$error("residual word %0d arrived with no pixel word pending",
					resid_ch.residual);
				fail_count++;
			end else begin
				want = pending_residuals.pop_front();
				if (resid_ch.residual !== want.residual) begin
					$error("residual: expected %0d, actual %0d", want.residual,
						resid_ch.residual);
					fail_count++;
				end
				if (resid_ch.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0b, actual %0b", want.frame_end,
						resid_ch.frame_end);
					fail_count++;
				end
				if (resid_ch.frame_end === 1'b1)
					frames_seen++;
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (pixel_ch.valid && pixel_ch.ready) ||
			(resid_ch.valid && resid_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus: directed frames first, then random phases.
	initial begin
		logic [CFG_BITS-1:0] value;
		int choice, count;
		cfg_we <= 1'b0;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// A 3x3 frame that hits both residual extremes outside the first pixel.
		write_register(REG_FRAME_WIDTH, 16'd3);
		write_register(REG_FRAME_HEIGHT, 16'd3);
		foreach (CORNER_FRAME[i])
			queue_pixel(CORNER_FRAME[i]);
		wait_idle();

		// Stop inside the second row, then shrink the frame so the next pixel
		// lies past the last column and row and must close the frame.
		repeat (4) queue_pixel(pixel_t'($urandom_range(0, 255)));
		wait_idle();
		write_register(REG_FRAME_WIDTH, 16'd1);
		write_register(REG_FRAME_HEIGHT, 16'd1);
		repeat (3) queue_pixel(pixel_t'($urandom_range(0, 255)));
		wait_idle();

		// Zero sizes act as one; an oversized width acts as the full line.
		write_register(REG_FRAME_WIDTH, 16'd0);
		write_register(REG_FRAME_HEIGHT, 16'd0);
		queue_pixel(8'd255);
		queue_pixel(8'd0);
		queue_pixel(8'd128);
		wait_idle();
		write_register(REG_FRAME_WIDTH, 16'hFFFF);
		write_register(REG_FRAME_HEIGHT, 16'hFFFF);
		repeat (4) queue_pixel(pixel_t'($urandom_range(0, 255)));
		wait_idle();

		// Random phases: mostly small frames so that many rows and frames complete.
		while (pixels_queued < PIXEL_TARGET) begin
			choice = $urandom_range(0, 3);
			if (choice[0]) begin
				case ($urandom_range(0, 9))
					0: value[WIDTH_BITS-1:0] = '0;
					1: value[WIDTH_BITS-1:0] = WIDTH_BITS'(MAX_WIDTH);
					2: value[WIDTH_BITS-1:0] = WIDTH_BITS'($urandom_range(MAX_WIDTH + 1, 8191));
					3: value[WIDTH_BITS-1:0] = WIDTH_BITS'(1);
					default: value[WIDTH_BITS-1:0] = WIDTH_BITS'($urandom_range(2, 16));
				endcase
				value[CFG_BITS-1:WIDTH_BITS] = 3'($urandom_range(0, 7));
				if (width_change_safe(value[WIDTH_BITS-1:0]))
					write_register(REG_FRAME_WIDTH, value);
			end
			if (choice[1]) begin
				case ($urandom_range(0, 7))
					0: value = '0;
					1: value = 16'hFFFF;
					2: value = 16'($urandom_range(0, 65535));
					3: value = 16'd1;
					default: value = 16'($urandom_range(2, 6));
				endcase
				write_register(REG_FRAME_HEIGHT, value);
			end
			case ($urandom_range(0, 3))
				0: begin sender_gap_max = 15; receiver_stall_max = 15; end
				1: begin sender_gap_max = 0; receiver_stall_max = 0; end
				2: begin sender_gap_max = 15; receiver_stall_max = 0; end
				default: begin sender_gap_max = 0; receiver_stall_max = 15; end
			endcase
			count = $urandom_range(10, 80);
			repeat (count) begin
				case ($urandom_range(0, 7))
					0: queue_pixel('0);
					1: queue_pixel('1);
					default: queue_pixel(pixel_t'($urandom_range(0, 255)));
				endcase
			end
			wait_idle();
		end

		// Let the pipeline settle and make sure nothing extra comes out.
		repeat (6) @(posedge clk);
		$display("covered %0d pixel words with %0d register writes", pixels_taken,
			register_writes);
		$display("%0d frame ends seen, %0d mismatches", frames_seen, fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
